// ===== rtl/core/cau_pkg.sv =====
// Package for the complex arithmetic unit.
// Holds operation codes, default widths and the control struct that runs down the pipeline.
`timescale 1ns / 1ps
package cau_pkg;

    localparam int CAU_WORD_BITS = 32;
    localparam int CAU_FRAC_BITS = 16;
    localparam int KIND_BITS     = 3;

    localparam logic [KIND_BITS-1:0] KIND_ADD  = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_SUB  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_MUL  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_DIV  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_CONJ = 3'd4;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic neg_re;
        logic neg_im;
        logic ov;
        logic dz;
    } cau_ctl_t;

endpackage

// ===== rtl/core/cau_front.sv =====
// Front end: request capture, products, sums and results of every code but divide.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_front
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS,
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [KIND_BITS-1:0]        kind,
    input  logic signed [WORD_BITS-1:0] a_real,
    input  logic signed [WORD_BITS-1:0] a_imag,
    input  logic signed [WORD_BITS-1:0] b_real,
    input  logic signed [WORD_BITS-1:0] b_imag,
    output cau_ctl_t                    ctl,
    output logic [WORD_BITS-1:0]        res_re,
    output logic [WORD_BITS-1:0]        res_im,
    output logic [2*WORD_BITS-1:0]      den,
    output logic [2*WORD_BITS-1:0]      mag_re,
    output logic [2*WORD_BITS-1:0]      mag_im
);
    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;
    localparam int SW = 2 * WORD_BITS + 2;
    localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;

    function automatic logic [W:0] sat_w(input logic signed [SW-1:0] x);
        logic [W:0] r;
        if (x > MAXV) r = {1'b1, MAXV[W-1:0]};
        else if (x < MINV) r = {1'b1, MINV[W-1:0]};
        else r = {1'b0, x[W-1:0]};
        return r;
    endfunction

    function automatic logic signed [SW-1:0] ext_p(input logic signed [PW-1:0] p);
        return {{(SW-PW){p[PW-1]}}, p};
    endfunction

    function automatic logic signed [SW-1:0] ext_w(input logic signed [W:0] v);
        return {{(SW-W-1){v[W]}}, v};
    endfunction

    // stage A: captured request
    logic                 va_reg;
    logic [KIND_BITS-1:0] ka_reg;
    logic signed [W-1:0]  ar_reg, ai_reg, br_reg, bi_reg;

    // stage B: products and simple results
    logic                 vb_reg;
    logic [KIND_BITS-1:0] kb_reg;
    logic                 bz_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    logic [W:0]           s_re_reg, s_im_reg;
    logic [W:0]           s_re_next, s_im_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ka_reg <= kind;
        ar_reg <= a_real;
        ai_reg <= a_imag;
        br_reg <= b_real;
        bi_reg <= b_imag;
    end

    always_comb
    begin
        case (ka_reg)
            KIND_ADD:
            begin
                s_re_next = sat_w(ext_w({ar_reg[W-1], ar_reg} + {br_reg[W-1], br_reg}));
                s_im_next = sat_w(ext_w({ai_reg[W-1], ai_reg} + {bi_reg[W-1], bi_reg}));
            end
            KIND_SUB:
            begin
                s_re_next = sat_w(ext_w({ar_reg[W-1], ar_reg} - {br_reg[W-1], br_reg}));
                s_im_next = sat_w(ext_w({ai_reg[W-1], ai_reg} - {bi_reg[W-1], bi_reg}));
            end
            KIND_CONJ:
            begin
                s_re_next = {1'b0, ar_reg};
                s_im_next = sat_w(ext_w(-{ai_reg[W-1], ai_reg}));
            end
            default:
            begin
                s_re_next = '0;
                s_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        kb_reg   <= ka_reg;
        bz_reg   <= (br_reg == '0) && (bi_reg == '0);
        p_rr_reg <= ar_reg * br_reg;
        p_ii_reg <= ai_reg * bi_reg;
        p_ri_reg <= ar_reg * bi_reg;
        p_ir_reg <= ai_reg * br_reg;
        p_bb_reg <= br_reg * br_reg;
        p_cc_reg <= bi_reg * bi_reg;
        s_re_reg <= s_re_next;
        s_im_reg <= s_im_next;
    end

    // stage C: multiply rescale, divide setup
    logic signed [SW-1:0] m_re, m_im, n_re_p, n_re_n, n_im_p, n_im_n;
    logic [W:0]           m_re_s, m_im_s;
    logic                 vc_valid;
    cau_ctl_t             ctl_next;
    logic [W-1:0]         re_next, im_next;

    assign m_re   = (ext_p(p_rr_reg) - ext_p(p_ii_reg)) >>> FRAC_BITS;
    assign m_im   = (ext_p(p_ri_reg) + ext_p(p_ir_reg)) >>> FRAC_BITS;
    assign m_re_s = sat_w(m_re);
    assign m_im_s = sat_w(m_im);
    assign n_re_p = ext_p(p_rr_reg) + ext_p(p_ii_reg);
    assign n_re_n = -ext_p(p_rr_reg) - ext_p(p_ii_reg);
    assign n_im_p = ext_p(p_ir_reg) - ext_p(p_ri_reg);
    assign n_im_n = ext_p(p_ri_reg) - ext_p(p_ir_reg);
    assign vc_valid = vb_reg;

    always_comb
    begin
        ctl_next       = '0;
        ctl_next.valid = vc_valid;
        ctl_next.neg_re = n_re_p[SW-1];
        ctl_next.neg_im = n_im_p[SW-1];
        re_next        = '0;
        im_next        = '0;
        case (kb_reg)
            KIND_MUL:
            begin
                re_next     = m_re_s[W-1:0];
                im_next     = m_im_s[W-1:0];
                ctl_next.ov = m_re_s[W] | m_im_s[W];
            end
            KIND_DIV:
            begin
                ctl_next.dz     = bz_reg;
                ctl_next.is_div = !bz_reg;
            end
            KIND_ADD, KIND_SUB, KIND_CONJ:
            begin
                re_next     = s_re_reg[W-1:0];
                im_next     = s_im_reg[W-1:0];
                ctl_next.ov = s_re_reg[W] | s_im_reg[W];
            end
            default:
            begin
                re_next = '0;
                im_next = '0;
            end
        endcase
    end

    cau_ctl_t ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        res_re <= re_next;
        res_im <= im_next;
        den    <= PW'(ext_p(p_bb_reg) + ext_p(p_cc_reg));
        mag_re <= n_re_p[SW-1] ? n_re_n[PW-1:0] : n_re_p[PW-1:0];
        mag_im <= n_im_p[SW-1] ? n_im_n[PW-1:0] : n_im_p[PW-1:0];
    end

    assign ctl = ctl_reg;

endmodule

// ===== rtl/core/cau_div_cell.sv =====
// One restoring-divide cell: one quotient bit for each part, the rest passes along.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_div_cell
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS,
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cau_ctl_t                            ctl_in,
    input  logic [WORD_BITS-1:0]                re_in,
    input  logic [WORD_BITS-1:0]                im_in,
    input  logic [2*WORD_BITS-1:0]              den_in,
    input  logic [2*WORD_BITS:0]                rem_re_in,
    input  logic [2*WORD_BITS:0]                rem_im_in,
    input  logic [2*WORD_BITS+FRAC_BITS-1:0]    nq_re_in,
    input  logic [2*WORD_BITS+FRAC_BITS-1:0]    nq_im_in,
    output cau_ctl_t                            ctl_out,
    output logic [WORD_BITS-1:0]                re_out,
    output logic [WORD_BITS-1:0]                im_out,
    output logic [2*WORD_BITS-1:0]              den_out,
    output logic [2*WORD_BITS:0]                rem_re_out,
    output logic [2*WORD_BITS:0]                rem_im_out,
    output logic [2*WORD_BITS+FRAC_BITS-1:0]    nq_re_out,
    output logic [2*WORD_BITS+FRAC_BITS-1:0]    nq_im_out
);
    localparam int RB = 2 * WORD_BITS + 1;
    localparam int QB = 2 * WORD_BITS + FRAC_BITS;

    logic [RB-1:0] t_re, t_im, d_ext;
    logic          q_re, q_im;

    // shift in the next numerator bit, subtract when it fits
    assign d_ext = {1'b0, den_in};
    assign t_re  = {rem_re_in[RB-2:0], nq_re_in[QB-1]};
    assign t_im  = {rem_im_in[RB-2:0], nq_im_in[QB-1]};
    assign q_re  = (t_re >= d_ext);
    assign q_im  = (t_im >= d_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_out <= '0;
        else
            ctl_out <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        re_out     <= re_in;
        im_out     <= im_in;
        den_out    <= den_in;
        rem_re_out <= q_re ? t_re - d_ext : t_re;
        rem_im_out <= q_im ? t_im - d_ext : t_im;
        nq_re_out  <= {nq_re_in[QB-2:0], q_re};
        nq_im_out  <= {nq_im_in[QB-2:0], q_im};
    end

endmodule

// ===== rtl/core/cau_back.sv =====
// Back end: quotient sign and saturation, result select and output register.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_back
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS,
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cau_ctl_t                            ctl,
    input  logic [WORD_BITS-1:0]                re_in,
    input  logic [WORD_BITS-1:0]                im_in,
    input  logic [2*WORD_BITS+FRAC_BITS-1:0]    q_re,
    input  logic [2*WORD_BITS+FRAC_BITS-1:0]    q_im,
    output logic                                done,
    output logic signed [WORD_BITS-1:0]         res_real,
    output logic signed [WORD_BITS-1:0]         res_imag,
    output logic                                overflow,
    output logic                                div_zero
);
    localparam int W  = WORD_BITS;
    localparam int QB = 2 * WORD_BITS + FRAC_BITS;
    localparam logic [QB-1:0] HALF = QB'(1) << (W - 1);
    localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W:0] fix_q(input logic [QB-1:0] q, input logic neg);
        logic [W:0] r;
        if (neg)
            r = (q > HALF) ? {1'b1, WMIN} : {1'b0, -q[W-1:0]};
        else
            r = (q >= HALF) ? {1'b1, WMAX} : {1'b0, q[W-1:0]};
        return r;
    endfunction

    logic [W:0] d_re, d_im;

    assign d_re = fix_q(q_re, ctl.neg_re);
    assign d_im = fix_q(q_im, ctl.neg_im);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done     <= 1'b0;
            overflow <= 1'b0;
            div_zero <= 1'b0;
        end
        else
        begin
            done     <= ctl.valid;
            overflow <= ctl.valid & (ctl.is_div ? (d_re[W] | d_im[W]) : ctl.ov);
            div_zero <= ctl.valid & ctl.dz;
        end
    end

    always_ff @(posedge clk)
    begin
        res_real <= ctl.is_div ? d_re[W-1:0] : re_in;
        res_imag <= ctl.is_div ? d_im[W-1:0] : im_in;
    end

endmodule

// ===== rtl/core/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: front end, divide cell chain, back end.
// Depends on cau_pkg, cau_front, cau_div_cell and cau_back.
//
//  channel   signals                                        handshake
//  request   kind a_real a_imag b_real b_imag               start, busy
//  result    res_real res_imag overflow div_zero            done (one-cycle strobe)
//
// A request is taken at every edge where start is high; busy is tied low, so one
// request enters each cycle. Every code passes through the divide chain, one cell per
// quotient bit; words are Q16.16 at the default widths.
// Reset clears the valid bits of every stage; payload needs no reset.
// The result strobe cannot be stalled, so no stage ever holds.
`timescale 1ns / 1ps
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS,
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [KIND_BITS-1:0]        kind,
    input  logic signed [WORD_BITS-1:0] a_real,
    input  logic signed [WORD_BITS-1:0] a_imag,
    input  logic signed [WORD_BITS-1:0] b_real,
    input  logic signed [WORD_BITS-1:0] b_imag,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] res_real,
    output logic signed [WORD_BITS-1:0] res_imag,
    output logic                        overflow,
    output logic                        div_zero
);
    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;
    localparam int RB = 2 * WORD_BITS + 1;
    localparam int QB = 2 * WORD_BITS + FRAC_BITS;

    // every stage advances every cycle
    assign busy = 1'b0;

    cau_ctl_t         ctl_c  [QB+1];
    logic [W-1:0]     re_c   [QB+1];
    logic [W-1:0]     im_c   [QB+1];
    logic [PW-1:0]    den_c  [QB+1];
    logic [RB-1:0]    rre_c  [QB+1];
    logic [RB-1:0]    rim_c  [QB+1];
    logic [QB-1:0]    nqre_c [QB+1];
    logic [QB-1:0]    nqim_c [QB+1];
    logic [PW-1:0]    mag_re, mag_im;

    cau_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .kind     (kind),
        .a_real   (a_real),
        .a_imag   (a_imag),
        .b_real   (b_real),
        .b_imag   (b_imag),
        .ctl      (ctl_c[0]),
        .res_re   (re_c[0]),
        .res_im   (im_c[0]),
        .den      (den_c[0]),
        .mag_re   (mag_re),
        .mag_im   (mag_im)
    );

    // the numerator magnitude enters scaled by the fraction bits; remainders start at zero
    assign rre_c[0]  = '0;
    assign rim_c[0]  = '0;
    assign nqre_c[0] = {mag_re, {FRAC_BITS{1'b0}}};
    assign nqim_c[0] = {mag_im, {FRAC_BITS{1'b0}}};

    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        cau_div_cell #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl_in     (ctl_c[i]),
            .re_in      (re_c[i]),
            .im_in      (im_c[i]),
            .den_in     (den_c[i]),
            .rem_re_in  (rre_c[i]),
            .rem_im_in  (rim_c[i]),
            .nq_re_in   (nqre_c[i]),
            .nq_im_in   (nqim_c[i]),
            .ctl_out    (ctl_c[i+1]),
            .re_out     (re_c[i+1]),
            .im_out     (im_c[i+1]),
            .den_out    (den_c[i+1]),
            .rem_re_out (rre_c[i+1]),
            .rem_im_out (rim_c[i+1]),
            .nq_re_out  (nqre_c[i+1]),
            .nq_im_out  (nqim_c[i+1])
        );
    end

    cau_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_c[QB]),
        .re_in    (re_c[QB]),
        .im_in    (im_c[QB]),
        .q_re     (nqre_c[QB]),
        .q_im     (nqim_c[QB]),
        .done     (done),
        .res_real (res_real),
        .res_imag (res_imag),
        .overflow (overflow),
        .div_zero (div_zero)
    );

endmodule

// ===== rtl/core/cau_checker.sv =====
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit.
`timescale 1ns / 1ps
module cau_checker
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS,
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic signed [WORD_BITS-1:0] res_real,
    input logic signed [WORD_BITS-1:0] res_imag,
    input logic                        overflow,
    input logic                        div_zero
);
    localparam int LAT = 4 + 2 * WORD_BITS + FRAC_BITS;

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching request");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        div_zero |-> (res_real == '0) && (res_imag == '0) && !overflow)
        else $error("divide by zero result not clean");

    a_flags_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !overflow && !div_zero)
        else $error("flag raised outside result strobe");

endmodule

bind complex_arithmetic_unit cau_checker #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_cau_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .res_real (res_real),
    .res_imag (res_imag),
    .overflow (overflow),
    .div_zero (div_zero)
);

// ===== test/tb_complex_arithmetic_unit.sv =====
// Testbench for the complex arithmetic unit: directed and random requests for every
// operation code, checked against a fixed-point predictor. Depends on cau_pkg and the RTL.
`timescale 1ns / 1ps
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int W       = CAU_WORD_BITS;
    localparam int F       = CAU_FRAC_BITS;
    localparam int LATENCY = 4 + 2 * W + F;
    localparam int N_RAND  = 1850;

    typedef struct {
        logic [KIND_BITS-1:0] kind;
        logic signed [W-1:0]  ar;
        logic signed [W-1:0]  ai;
        logic signed [W-1:0]  br;
        logic signed [W-1:0]  bi;
    } request_t;

    typedef struct {
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
        logic                ov;
        logic                dz;
    } cplx_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [KIND_BITS-1:0] kind = '0;
    logic signed [W-1:0]  a_real = '0;
    logic signed [W-1:0]  a_imag = '0;
    logic signed [W-1:0]  b_real = '0;
    logic signed [W-1:0]  b_imag = '0;
    logic                 done;
    logic signed [W-1:0]  res_real;
    logic signed [W-1:0]  res_imag;
    logic                 overflow;
    logic                 div_zero;

    request_t     pending_q[$];
    cplx_result_t awaited_q[$];
    int           errors = 0;
    int           n_sent = 0;
    int           n_checked = 0;
    int           kind_seen[8];
    bit           feeding_done = 1'b0;
    bit           drain_hold = 1'b0;

    always #2 clk = ~clk;

    complex_arithmetic_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .a_real   (a_real),
        .a_imag   (a_imag),
        .b_real   (b_real),
        .b_imag   (b_imag),
        .done     (done),
        .res_real (res_real),
        .res_imag (res_imag),
        .overflow (overflow),
        .div_zero (div_zero)
    );

    // Clamp a wide signed value to the word range; flag when clamped.
    function automatic logic signed [W-1:0] clamp_word(input logic signed [127:0] x,
                                                       inout logic ov);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        begin
            hi_lim = (128'sd1 <<< (W - 1)) - 1;
            lo_lim = -(128'sd1 <<< (W - 1));
            if (x > hi_lim)
            begin
                ov = 1'b1;
                return hi_lim[W-1:0];
            end
            if (x < lo_lim)
            begin
                ov = 1'b1;
                return lo_lim[W-1:0];
            end
            return x[W-1:0];
        end
    endfunction

    // Scaled divide, truncated toward zero.
    function automatic logic signed [127:0] scaled_quot(input logic signed [127:0] num,
                                                        input logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        begin
            mag = num[127] ? -num : num;
            q = (mag << F) / den;
            return num[127] ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic cplx_result_t compute_complex(input request_t r);
        cplx_result_t        o;
        logic signed [127:0] ar, ai, br, bi, re, im, den;
        logic                ok;
        begin
            ar = r.ar; ai = r.ai; br = r.br; bi = r.bi;
            re = '0; im = '0; ok = 1'b1;
            o.ov = 1'b0; o.dz = 1'b0;
            case (r.kind)
                KIND_ADD:
                begin
                    re = ar + br; im = ai + bi;
                end
                KIND_SUB:
                begin
                    re = ar - br; im = ai - bi;
                end
                KIND_MUL:
                begin
                    re = (ar * br - ai * bi) >>> F;
                    im = (ar * bi + ai * br) >>> F;
                end
                KIND_DIV:
                begin
                    if (br == 0 && bi == 0)
                        o.dz = 1'b1;
                    else
                    begin
                        den = br * br + bi * bi;
                        re = scaled_quot(ar * br + ai * bi, den);
                        im = scaled_quot(ai * br - ar * bi, den);
                    end
                end
                KIND_CONJ:
                begin
                    re = ar; im = -ai;
                end
                default: ok = 1'b0;
            endcase
            o.re = ok ? clamp_word(re, o.ov) : '0;
            o.im = ok ? clamp_word(im, o.ov) : '0;
            return o;
        end
    endfunction

    function automatic logic signed [W-1:0] rand_part();
        logic signed [W-1:0] v;
        begin
            case ($urandom_range(0, 7))
                0: v = {1'b1, {(W-1){1'b0}}};
                1: v = {1'b0, {(W-1){1'b1}}};
                2: v = '0;
                3: v = W'($signed($urandom_range(0, 1 << 20)) - (1 <<< 19));
                4: v = W'($signed({$urandom_range(0, 3), {F{1'b0}}})
                          * ($urandom_range(0, 1) ? 1 : -1));
                default: v = W'($urandom);
            endcase
            return v;
        end
    endfunction

    task automatic push_request(input logic [KIND_BITS-1:0] k, input logic signed [W-1:0] ar,
                                input logic signed [W-1:0] ai, input logic signed [W-1:0] br,
                                input logic signed [W-1:0] bi);
        request_t r;
        begin
            r.kind = k; r.ar = ar; r.ai = ai; r.br = br; r.bi = bi;
            pending_q.push_back(r);
        end
    endtask

    // Driver: change inputs on the falling edge; a request goes in at each rising edge
    // with start high and busy low. Hold start high across back-to-back requests.
    always @(negedge clk)
    begin
        request_t r;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                awaited_q.push_back(compute_complex(pending_q.pop_front()));
                n_sent++;
            end
            if (start && busy)
                ;   // hold the request until the block takes it
            else if (pending_q.size() > 0 && !drain_hold && $urandom_range(0, 3) != 0)
            begin
                r = pending_q[0];
                start <= 1'b1;
                kind <= r.kind; a_real <= r.ar; a_imag <= r.ai;
                b_real <= r.br; b_imag <= r.bi;
            end
            else
            begin
                start <= 1'b0;
                kind <= KIND_BITS'($urandom); a_real <= W'($urandom); a_imag <= W'($urandom);
                b_real <= W'($urandom); b_imag <= W'($urandom);
            end
        end
    end

    // Monitor: sample the strobe at the rising edge; compare with the oldest prediction.
    always @(posedge clk)
    begin
        cplx_result_t e;
        if (rst_n && done)
        begin
            if (awaited_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: re=%h im=%h", $time,
                         res_real, res_imag);
                errors++;
            end
            else
            begin
                e = awaited_q.pop_front();
                n_checked++;
                if (res_real !== e.re)
                begin
                    $display("%0t: res_real expected %h actual %h", $time, e.re, res_real);
                    errors++;
                end
                if (res_imag !== e.im)
                begin
                    $display("%0t: res_imag expected %h actual %h", $time, e.im, res_imag);
                    errors++;
                end
                if (overflow !== e.ov)
                begin
                    $display("%0t: overflow expected %b actual %b", $time, e.ov, overflow);
                    errors++;
                end
                if (div_zero !== e.dz)
                begin
                    $display("%0t: div_zero expected %b actual %b", $time, e.dz, div_zero);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic signed [W-1:0] mx, mn, one;
        int                  gap;
        mx = {1'b0, {(W-1){1'b1}}};
        mn = {1'b1, {(W-1){1'b0}}};
        one = 1 <<< F;
        // Directed: extremes, every code, divide by zero, conjugate of most negative.
        push_request(KIND_ADD, mx, mx, one, one);
        push_request(KIND_ADD, mn, mn, -one, -one);
        push_request(KIND_SUB, mn, mx, one, -one);
        push_request(KIND_SUB, 3 * one, -one, one, one);
        push_request(KIND_MUL, mx, mx, mx, mx);
        push_request(KIND_MUL, mn, mn, mn, mn);
        push_request(KIND_MUL, mn, '0, mn, '0);
        push_request(KIND_MUL, -1, 1, 1, -1);
        push_request(KIND_MUL, 2 * one, 3 * one, -one, one);
        push_request(KIND_DIV, one, one, '0, '0);
        push_request(KIND_DIV, mx, mn, '0, '0);
        push_request(KIND_DIV, mx, mx, 1, 0);
        push_request(KIND_DIV, mn, mn, 0, -1);
        push_request(KIND_DIV, 2 * one, one, one, -one);
        push_request(KIND_DIV, -7, 3, mn, mn);
        push_request(KIND_CONJ, mn, mn, mx, mx);
        push_request(KIND_CONJ, mx, mx, '0, '0);
        push_request(KIND_CONJ, -one, '0, '0, '0);
        push_request(3'd5, mx, mx, mx, mx);
        push_request(3'd6, one, one, one, one);
        push_request(3'd7, mn, mn, mn, mn);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_RAND; i++)
        begin
            logic [KIND_BITS-1:0] k;
            k = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            kind_seen[k]++;
            push_request(k, rand_part(), rand_part(), rand_part(), rand_part());
            // Insert an occasional long gap by pausing the feed.
            if ($urandom_range(0, 99) == 0)
            begin
                wait (pending_q.size() == 0);
                gap = $urandom_range(20, 200);
                repeat (gap) @(posedge clk);
            end
            // Pause once until the pipeline drains completely.
            if (i == N_RAND / 2)
            begin
                wait (pending_q.size() == 0);
                @(negedge clk);
                drain_hold = 1'b1;
                wait (awaited_q.size() == 0 && !start);
                drain_hold = 1'b0;
            end
        end
        wait (pending_q.size() == 0);
        @(negedge clk);
        @(negedge clk);
        wait (awaited_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("covered %0d requests, %0d results checked across all five operations",
                 n_sent, n_checked);
        $display("unused codes sent: %0d", kind_seen[5] + kind_seen[6] + kind_seen[7]);
        if (errors == 0 && awaited_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
